>>> hw/rtl/lsc_pkg.sv
// ============================================================================
// lsc_pkg: shared types and constants of the laser stripe centroid unit
// Pixel and center item layouts, fixed-point format, register indexes.
// ============================================================================
`default_nettype none

package lsc_pkg;

  // fixed-point format of the center: Q(COORD_BITS).(FRACTION_BITS)
  localparam int unsigned COORD_BITS    = 12;
  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned CENTER_BITS   = COORD_BITS + FRACTION_BITS;
  localparam int unsigned PIXEL_BITS    = 8;
  localparam int unsigned CFG_BITS      = 8;
  localparam int unsigned WIDTH_BITS    = 8;
  localparam int unsigned WIDTH_SAT     = 255;

  // configuration port
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam logic        REG_MIN_WIDTH = 1'b0;
  localparam logic        REG_MAX_WIDTH = 1'b1;
  localparam logic [CFG_BITS-1:0] MIN_WIDTH_RESET = 8'd0;
  localparam logic [CFG_BITS-1:0] MAX_WIDTH_RESET = 8'd255;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_value;
    logic                  in_mask;
    logic [COORD_BITS-1:0] position;
    logic [COORD_BITS-1:0] line_number;
    logic                  first_in_line;
  } pixel_t;

  typedef struct packed {
    logic [CENTER_BITS-1:0] center_position;
    logic [COORD_BITS-1:0]  center_line;
    logic [WIDTH_BITS-1:0]  stripe_width;
  } center_t;

endpackage

`default_nettype wire

>>> hw/rtl/lsc_front.sv
// ============================================================================
// lsc_front: stripe tracker
// Accepts pixels, accumulates weight and moment of the open stripe, and
// pushes a division job when an unmasked pixel closes a valid stripe.
// ============================================================================
`default_nettype none

module lsc_front #(
  parameter int unsigned LEN_BITS = 9,
  parameter int unsigned JOB_BITS = 72
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                pixel_valid,
  output logic                               pixel_ready,
  input  wire lsc_pkg::pixel_t               pixel,
  input  wire [lsc_pkg::CFG_BITS-1:0]        min_width,
  input  wire [LEN_BITS-1:0]                 limit,
  output logic                               job_push,
  output logic [JOB_BITS-1:0]                job_data,
  input  wire                                job_full
);

  localparam int unsigned WSUM_BITS = LEN_BITS + lsc_pkg::PIXEL_BITS;
  localparam int unsigned MOM_BITS  = 2 * LEN_BITS + lsc_pkg::PIXEL_BITS;

  typedef enum logic [1:0] {
    RUN_OUTSIDE = 2'd0,
    RUN_INSIDE  = 2'd1,
    RUN_REJECT  = 2'd2
  } run_state_t;

  typedef struct packed {
    logic [MOM_BITS-1:0]            moment;
    logic [WSUM_BITS-1:0]           weight;
    logic [lsc_pkg::COORD_BITS-1:0] start;
    logic [lsc_pkg::COORD_BITS-1:0] line;
    logic [LEN_BITS-1:0]            len;
  } job_t;

  run_state_t                     state, state_next, eff;
  logic [LEN_BITS-1:0]            run_length, run_length_next, len_base, len_inc;
  logic [WSUM_BITS-1:0]           weight_sum, weight_sum_next, w_base;
  logic [MOM_BITS-1:0]            moment_sum, moment_sum_next, m_base;
  logic [lsc_pkg::COORD_BITS-1:0] stripe_start, stripe_start_next;
  logic [lsc_pkg::COORD_BITS-1:0] current_line, current_line_next;
  logic [WSUM_BITS-1:0]           product;
  logic                           start_new, emit, accept;
  job_t                           job;

  assign pixel_ready = !job_full;
  assign accept      = pixel_valid && pixel_ready;

  assign product = WSUM_BITS'(len_base) * WSUM_BITS'(pixel.pixel_value);
  assign len_inc = len_base + LEN_BITS'(1);

  always_comb begin
    eff       = pixel.first_in_line ? RUN_OUTSIDE : state;
    start_new = pixel.in_mask && (eff == RUN_OUTSIDE);
    len_base  = start_new ? '0 : run_length;
    w_base    = start_new ? '0 : weight_sum;
    m_base    = start_new ? '0 : moment_sum;

    state_next        = eff;
    run_length_next   = run_length;
    weight_sum_next   = weight_sum;
    moment_sum_next   = moment_sum;
    stripe_start_next = start_new ? pixel.position : stripe_start;
    current_line_next = start_new ? pixel.line_number : current_line;
    emit              = 1'b0;

    if (pixel.in_mask) begin
      if (eff != RUN_REJECT) begin
        run_length_next = len_inc;
        weight_sum_next = w_base + WSUM_BITS'(pixel.pixel_value);
        moment_sum_next = m_base + MOM_BITS'(product);
        state_next      = (len_inc > limit) ? RUN_REJECT : RUN_INSIDE;
      end
    end else begin
      state_next = RUN_OUTSIDE;
      emit       = (eff == RUN_INSIDE) && (16'(run_length) > 16'(min_width)) &&
                   (weight_sum != '0);
    end
  end

  always_comb begin
    job.moment = moment_sum;
    job.weight = weight_sum;
    job.start  = stripe_start;
    job.line   = current_line;
    job.len    = run_length;
  end

  assign job_push = accept && emit;
  assign job_data = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= RUN_OUTSIDE;
      run_length   <= '0;
      weight_sum   <= '0;
      moment_sum   <= '0;
      stripe_start <= '0;
      current_line <= '0;
    end else if (accept) begin
      state        <= state_next;
      run_length   <= run_length_next;
      weight_sum   <= weight_sum_next;
      moment_sum   <= moment_sum_next;
      stripe_start <= stripe_start_next;
      current_line <= current_line_next;
    end
  end

  // a pushed job always has a usable divisor and a nonzero width
  a_job_nonzero: assert property (@(posedge clk) disable iff (rst)
    job_push |-> (weight_sum != '0) && (run_length != '0))
    else $error("job pushed with zero weight or width");

endmodule

`default_nettype wire

>>> hw/rtl/lsc_queue.sv
// ============================================================================
// lsc_queue: job queue
// Small register FIFO between the stripe tracker and the divider.
// ============================================================================
`default_nettype none

module lsc_queue #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  push_data,
  output logic             full,
  input  wire              pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full      = (count == CNT_BITS'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> hw/rtl/lsc_back.sv
// ============================================================================
// lsc_back: centroid divider
// Restoring division of moment by weight, one quotient bit per cycle, then
// add the stripe start, saturate and hold the center in an output register.
// ============================================================================
`default_nettype none

module lsc_back #(
  parameter int unsigned LEN_BITS = 9,
  parameter int unsigned JOB_BITS = 72
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  job_valid,
  input  wire [JOB_BITS-1:0]   job_data,
  output logic                 job_pop,
  output logic                 center_valid,
  input  wire                  center_ready,
  output lsc_pkg::center_t     center
);

  localparam int unsigned F         = lsc_pkg::FRACTION_BITS;
  localparam int unsigned COORD     = lsc_pkg::COORD_BITS;
  localparam int unsigned WSUM_BITS = LEN_BITS + lsc_pkg::PIXEL_BITS;
  localparam int unsigned MOM_BITS  = 2 * LEN_BITS + lsc_pkg::PIXEL_BITS;
  localparam int unsigned QUO_BITS  = LEN_BITS + F;
  localparam int unsigned CNT_BITS  = $clog2(QUO_BITS);
  localparam int unsigned SUM_BITS  = ((COORD > LEN_BITS) ? COORD : LEN_BITS) + F + 1;
  localparam int unsigned CB        = lsc_pkg::CENTER_BITS;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_DONE = 2'd2
  } div_state_t;

  typedef struct packed {
    logic [MOM_BITS-1:0]  moment;
    logic [WSUM_BITS-1:0] weight;
    logic [COORD-1:0]     start;
    logic [COORD-1:0]     line;
    logic [LEN_BITS-1:0]  len;
  } job_t;

  div_state_t           state;
  job_t                 job;
  logic [WSUM_BITS-1:0] rem, divisor;
  logic [QUO_BITS-1:0]  quo;
  logic [CNT_BITS-1:0]  count;
  logic [COORD-1:0]     start, line;
  logic [LEN_BITS-1:0]  len;
  logic [WSUM_BITS:0]   trial;
  logic                 take;
  logic [SUM_BITS-1:0]  sum;
  lsc_pkg::center_t     result;

  assign job     = job_data;
  assign job_pop = (state == DIV_IDLE) && job_valid;
  assign trial   = {rem, quo[QUO_BITS-1]};
  assign take    = (trial >= {1'b0, divisor});
  assign sum     = SUM_BITS'({start, {F{1'b0}}}) + SUM_BITS'(quo);

  always_comb begin
    result.center_position = (sum[SUM_BITS-1:CB] != '0) ? '1 : sum[CB-1:0];
    result.center_line     = line;
    result.stripe_width    = (16'(len) > 16'(lsc_pkg::WIDTH_SAT)) ? '1 :
                             lsc_pkg::WIDTH_BITS'(len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= DIV_IDLE;
      center_valid <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (center_valid && center_ready && (state != DIV_DONE)) begin
        center_valid <= 1'b0;
      end
      case (state)
        DIV_IDLE: begin
          if (job_valid) begin
            // quotient is known to fit QUO_BITS, so skip the leading steps
            rem     <= job.moment[MOM_BITS-1:LEN_BITS];
            quo     <= {job.moment[LEN_BITS-1:0], {F{1'b0}}};
            divisor <= job.weight;
            start   <= job.start;
            line    <= job.line;
            len     <= job.len;
            count   <= CNT_BITS'(QUO_BITS - 1);
            state   <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          rem   <= take ? WSUM_BITS'(trial - {1'b0, divisor}) : trial[WSUM_BITS-1:0];
          quo   <= {quo[QUO_BITS-2:0], take};
          count <= count - CNT_BITS'(1);
          if (count == '0) begin
            state <= DIV_DONE;
          end
        end
        DIV_DONE: begin
          if (!center_valid || center_ready) begin
            center       <= result;
            center_valid <= 1'b1;
            state        <= DIV_IDLE;
          end
        end
        default: begin
          state <= DIV_IDLE;
        end
      endcase
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == DIV_RUN) |-> (rem < divisor))
    else $error("partial remainder not below divisor");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(center_valid) |-> $past(state == DIV_DONE))
    else $error("center loaded outside done state");

endmodule

`default_nettype wire

>>> hw/rtl/laser_stripe_centroid_unit.sv
// ============================================================================
// laser_stripe_centroid_unit: gray-gravity laser stripe center finder
// Finds runs of masked pixels along scan lines and emits each run's
// brightness-weighted center in unsigned Q12.8.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+------------------
//   pixel    | in        | pixel_valid / pixel_ready    | lsc_pkg::pixel_t
//   center   | out       | center_valid / center_ready  | lsc_pkg::center_t
//   config   | in        | psel / penable / pwrite      | min_width, max_width
//
// Pixels are taken one per cycle whenever the job queue has room; the
// stripe tracker keeps its accumulators up to date with one multiply-add.
// Each emitted stripe occupies the divider through a load step, one step
// per quotient bit and a write of the output register, and the divider
// takes no new job until then. That serial divider sets the stripe rate.
// Reset is synchronous and clears all control state; no clearing pass.
// A stalled center output holds the divider after its current job; the
// queue then fills and pixel_ready drops until room frees up.
// ============================================================================
`default_nettype none

module laser_stripe_centroid_unit #(
  parameter int unsigned MAX_STRIPE  = 255,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                                clk,
  input  wire                                rst,
  // pixel stream
  input  wire                                pixel_valid,
  output logic                               pixel_ready,
  input  wire lsc_pkg::pixel_t               pixel,
  // center results
  output logic                               center_valid,
  input  wire                                center_ready,
  output lsc_pkg::center_t                   center,
  // configuration port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [lsc_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire [lsc_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [lsc_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  // run length must reach one past the longest legal stripe
  localparam int unsigned LEN_BITS  = $clog2(MAX_STRIPE + 2);
  localparam int unsigned WSUM_BITS = LEN_BITS + lsc_pkg::PIXEL_BITS;
  localparam int unsigned MOM_BITS  = 2 * LEN_BITS + lsc_pkg::PIXEL_BITS;
  localparam int unsigned JOB_BITS  = MOM_BITS + WSUM_BITS + 2 * lsc_pkg::COORD_BITS +
                                      LEN_BITS;

  logic [lsc_pkg::CFG_BITS-1:0] min_width, max_width;
  logic [LEN_BITS-1:0]          limit;
  logic                         cfg_write;

  logic                q_push, q_full, q_pop, q_valid;
  logic [JOB_BITS-1:0] q_in, q_out;

  // --------------------------------------------------------------------------
  // Configuration registers: always ready, write on the access phase.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= lsc_pkg::MIN_WIDTH_RESET;
      max_width <= lsc_pkg::MAX_WIDTH_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        lsc_pkg::REG_MIN_WIDTH: min_width <= pwdata[lsc_pkg::CFG_BITS-1:0];
        lsc_pkg::REG_MAX_WIDTH: max_width <= pwdata[lsc_pkg::CFG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lsc_pkg::REG_MIN_WIDTH: prdata = lsc_pkg::APB_DATA_BITS'(min_width);
      lsc_pkg::REG_MAX_WIDTH: prdata = lsc_pkg::APB_DATA_BITS'(max_width);
      default:                prdata = '0;
    endcase
  end

  // Reject threshold: the smaller of max_width and the build-time limit.
  assign limit = (32'(max_width) < 32'(MAX_STRIPE)) ? LEN_BITS'(max_width) :
                 LEN_BITS'(MAX_STRIPE);

  // --------------------------------------------------------------------------
  // Front: track stripes and push finished ones as division jobs.
  // --------------------------------------------------------------------------
  lsc_front #(
    .LEN_BITS (LEN_BITS),
    .JOB_BITS (JOB_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .min_width   (min_width),
    .limit       (limit),
    .job_push    (q_push),
    .job_data    (q_in),
    .job_full    (q_full)
  );

  // --------------------------------------------------------------------------
  // Queue: decouple the pixel side from the divider.
  // --------------------------------------------------------------------------
  lsc_queue #(
    .WIDTH (JOB_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  // --------------------------------------------------------------------------
  // Back: divide, add the stripe start, saturate, hold the result.
  // --------------------------------------------------------------------------
  lsc_back #(
    .LEN_BITS (LEN_BITS),
    .JOB_BITS (JOB_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_valid),
    .job_data     (q_out),
    .job_pop      (q_pop),
    .center_valid (center_valid),
    .center_ready (center_ready),
    .center       (center)
  );

endmodule

`default_nettype wire

>>> tb/tb_laser_stripe_centroid_unit.sv
// ----------------------------------------------------------------------------
// tb_laser_stripe_centroid_unit: self-checking bench for the stripe centroid
// Streams pixel items through the unit, tracks stripes in a behavioral
// predictor and compares every center item field by field, in order.
// Covers directed stripe shapes, width limits, random scan lines and
// sender/receiver flow control.
// ----------------------------------------------------------------------------
module tb_laser_stripe_centroid_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lsc_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned MAX_STRIPE   = 255;
  // Four queued stripes through the divider, plus margin.
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [63:0] CENTER_MAX   = (64'd1 << CENTER_BITS) - 64'd1;

  typedef enum logic [1:0] {
    STRIPE_OUTSIDE,
    STRIPE_OPEN,
    STRIPE_REJECTED
  } stripe_state_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic    pixel_valid = 1'b0;
  logic    pixel_ready;
  pixel_t  pixel = '0;
  logic    center_valid;
  logic    center_ready = 1'b0;
  center_t center;

  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  always #(CLK_PERIOD / 2) clk = ~clk;

  laser_stripe_centroid_unit dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .center_valid (center_valid),
    .center_ready (center_ready),
    .center       (center),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // --------------------------------------------------------------------------
  // Stripe tracker: mirrors the unit's state and configuration
  // --------------------------------------------------------------------------
  logic [CFG_BITS-1:0]   cfg_min_width = MIN_WIDTH_RESET;
  logic [CFG_BITS-1:0]   cfg_max_width = MAX_WIDTH_RESET;
  stripe_state_t         stripe_state  = STRIPE_OUTSIDE;
  int unsigned           run_len       = 0;
  logic [63:0]           weight_sum    = '0;
  logic [63:0]           moment_sum    = '0;
  logic [COORD_BITS-1:0] start_pos     = '0;
  logic [COORD_BITS-1:0] stripe_line   = '0;

  center_t     centers_due[$];
  int unsigned center_errors = 0;

  // Idling controls, in percent of cycles.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // Advance the tracker by one accepted pixel; queue the center it closes.
  function automatic void track_pixel(input pixel_t p);
    int unsigned cap;
    logic [63:0] frac;
    logic [63:0] pos_q;
    center_t     c;
    cap = (cfg_max_width < MAX_STRIPE) ? cfg_max_width : MAX_STRIPE;
    // A new line drops whatever stripe is open or rejected.
    if (p.first_in_line) stripe_state = STRIPE_OUTSIDE;
    if (p.in_mask) begin
      if (stripe_state == STRIPE_OUTSIDE) begin
        stripe_state = STRIPE_OPEN;
        run_len      = 0;
        weight_sum   = '0;
        moment_sum   = '0;
        start_pos    = p.position;
        stripe_line  = p.line_number;
      end
      if (stripe_state == STRIPE_OPEN) begin
        moment_sum += 64'(run_len) * 64'(p.pixel_value);
        weight_sum += 64'(p.pixel_value);
        run_len++;
        // Too wide: reject the whole stripe, ignore the rest of its pixels.
        if (run_len > cap) stripe_state = STRIPE_REJECTED;
      end
    end else begin
      if (stripe_state == STRIPE_OPEN && run_len > cfg_min_width && weight_sum != 0) begin
        // Truncating divide, then saturate a center beyond Q12.8 range.
        frac  = (moment_sum << FRACTION_BITS) / weight_sum;
        pos_q = (64'(start_pos) << FRACTION_BITS) + frac;
        if (pos_q > CENTER_MAX) pos_q = CENTER_MAX;
        c.center_position = pos_q[CENTER_BITS-1:0];
        c.center_line     = stripe_line;
        c.stripe_width    = WIDTH_BITS'((run_len > WIDTH_SAT) ? WIDTH_SAT : run_len);
        centers_due = {centers_due, c};
      end
      stripe_state = STRIPE_OUTSIDE;
    end
  endfunction

  function automatic pixel_t make_pixel(input logic [PIXEL_BITS-1:0] value, input logic mask,
                                        input logic [COORD_BITS-1:0] pos,
                                        input logic [COORD_BITS-1:0] line,
                                        input logic new_line);
    pixel_t p;
    p.pixel_value   = value;
    p.in_mask       = mask;
    p.position      = pos;
    p.line_number   = line;
    p.first_in_line = new_line;
    return p;
  endfunction

  function automatic void report_mismatch(input string what, input center_t want,
                                          input center_t got);
    center_errors++;
    if (center_errors <= REPORT_LIMIT)
      $display("%t %s mismatch: expected %h/%h/%0d, got %h/%h/%0d",
               $realtime, what, want.center_position, want.center_line, want.stripe_width,
               got.center_position, got.center_line, got.stripe_width);
  endfunction

  // --------------------------------------------------------------------------
  // Pixel sender: idle at random, then hold the item until it is accepted.
  // Valid stays high between back-to-back items.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_ready !== 1'b1);
    track_pixel(p);
  endtask

  // Drop valid, wait for every queued center, then let the divider settle.
  task automatic drain_centers();
    if (pixel_valid) pixel_valid <= 1'b0;
    while (centers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB write: setup, then access until pready. Leave psel high so that
  // back-to-back writes need no extra idle cycle.
  task automatic apb_write(input logic reg_idx, input logic [CFG_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= APB_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (reg_idx == REG_MIN_WIDTH) cfg_min_width = value;
    else cfg_max_width = value;
  endtask

  // Reconfigure only with the unit idle.
  task automatic apply_config(input logic [CFG_BITS-1:0] min_w, input logic [CFG_BITS-1:0] max_w);
    drain_centers();
    apb_write(REG_MIN_WIDTH, min_w);
    apb_write(REG_MAX_WIDTH, max_w);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random scan lines: mostly well-formed stripes with random brightness,
  // some raw noise items, unclosed stripes and line changes.
  // --------------------------------------------------------------------------
  task automatic send_scan_lines(input int unsigned n_items, input int unsigned long_quota);
    int unsigned           sent;
    int unsigned           cap;
    int unsigned           hi;
    int unsigned           wid;
    int unsigned           pick;
    int unsigned           long_left;
    logic [COORD_BITS-1:0] pos;
    logic [COORD_BITS-1:0] line;
    logic                  new_line;
    logic                  dark_run;
    logic [63:0]           noise;
    sent      = 0;
    long_left = long_quota;
    pos       = COORD_BITS'($urandom_range(4095));
    line      = COORD_BITS'($urandom_range(4095));
    cap       = (cfg_max_width < MAX_STRIPE) ? cfg_max_width : MAX_STRIPE;
    hi        = (cap < 12) ? cap + 1 : 12;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        noise = {$urandom(), $urandom()};
        send_pixel(noise[$bits(pixel_t)-1:0]);
        sent++;
      end else begin
        new_line = ($urandom_range(3) == 0);
        if (new_line) begin
          line = COORD_BITS'($urandom_range(4095));
          pos  = COORD_BITS'($urandom_range(4095));
        end else if ($urandom_range(19) == 0) begin
          // line moves on without a line start
          line = COORD_BITS'($urandom_range(4095));
        end
        repeat ($urandom_range(2)) begin
          send_pixel(make_pixel(8'($urandom_range(255)), 1'b0, pos, line, new_line));
          new_line = 1'b0;
          pos++;
          sent++;
        end
        // Favor short stripes; hit the min and max width edges now and then.
        pick = $urandom_range(99);
        if (pick < 15 && cfg_min_width < 40) begin
          wid = cfg_min_width + $urandom_range(1);
          if (wid == 0) wid = 1;
        end else if (pick < 25 && (cap <= 64 || long_left > 0)) begin
          wid = cap + $urandom_range(1);
          if (cap > 64) long_left--;
        end else begin
          wid = $urandom_range(hi, 1);
        end
        dark_run = ($urandom_range(9) == 0);
        repeat (wid) begin
          send_pixel(make_pixel(dark_run ? 8'd0 : 8'($urandom_range(255)), 1'b1, pos, line,
                                new_line));
          new_line = 1'b0;
          pos++;
          sent++;
        end
        // Leave some stripes open so a later line start or stripe meets them.
        if ($urandom_range(9) != 0) begin
          send_pixel(make_pixel(8'($urandom_range(255)), 1'b0, pos, line, 1'b0));
          pos++;
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_stripe_shapes();
    idle_pct  = 0;
    stall_pct = 0;
    // single full-brightness pixel at the origin, on the last line
    send_pixel(make_pixel(8'd0,   1'b0, 12'd0,    12'd0,    1'b1));
    send_pixel(make_pixel(8'd255, 1'b1, 12'd0,    12'd4095, 1'b0));
    send_pixel(make_pixel(8'd7,   1'b0, 12'd1,    12'd4095, 1'b0));
    // stripe at the far end, weight on its second pixel: saturates
    send_pixel(make_pixel(8'd0,   1'b1, 12'd4095, 12'd3,    1'b0));
    send_pixel(make_pixel(8'd255, 1'b1, 12'd0,    12'd3,    1'b0));
    send_pixel(make_pixel(8'd0,   1'b0, 12'd1,    12'd3,    1'b0));
    // all-dark stripe emits nothing
    send_pixel(make_pixel(8'd0,   1'b1, 12'd10,   12'd3,    1'b0));
    send_pixel(make_pixel(8'd0,   1'b1, 12'd11,   12'd3,    1'b0));
    send_pixel(make_pixel(8'd90,  1'b0, 12'd12,   12'd3,    1'b0));
    // line number changes mid-stripe; fraction truncates (768 / 5)
    send_pixel(make_pixel(8'd3,   1'b1, 12'd100,  12'd7,    1'b0));
    send_pixel(make_pixel(8'd1,   1'b1, 12'd101,  12'd8,    1'b0));
    send_pixel(make_pixel(8'd1,   1'b1, 12'd102,  12'd8,    1'b0));
    send_pixel(make_pixel(8'd1,   1'b0, 12'd103,  12'd8,    1'b0));
    // line start discards an open stripe and opens a fresh one
    send_pixel(make_pixel(8'd50,  1'b1, 12'd200,  12'd8,    1'b0));
    send_pixel(make_pixel(8'd10,  1'b1, 12'd0,    12'd9,    1'b1));
    send_pixel(make_pixel(8'd10,  1'b0, 12'd1,    12'd9,    1'b0));
    drain_centers();
  endtask

  task automatic test_width_limits();
    apply_config(8'd255, 8'd1);
    // second pixel rejects the stripe, the third is ignored
    send_pixel(make_pixel(8'd9,   1'b1, 12'd10,   12'd1,    1'b1));
    send_pixel(make_pixel(8'd9,   1'b1, 12'd11,   12'd1,    1'b0));
    send_pixel(make_pixel(8'd9,   1'b1, 12'd12,   12'd1,    1'b0));
    send_pixel(make_pixel(8'd9,   1'b0, 12'd13,   12'd1,    1'b0));
    // one pixel is never longer than 255
    send_pixel(make_pixel(8'd40,  1'b1, 12'd20,   12'd1,    1'b0));
    send_pixel(make_pixel(8'd40,  1'b0, 12'd21,   12'd1,    1'b0));
    apply_config(8'd0, 8'd1);
    send_pixel(make_pixel(8'd200, 1'b1, 12'd4095, 12'd4095, 1'b0));
    send_pixel(make_pixel(8'd0,   1'b0, 12'd0,    12'd4095, 1'b0));
    send_pixel(make_pixel(8'd0,   1'b1, 12'd5,    12'd2,    1'b0));
    send_pixel(make_pixel(8'd0,   1'b0, 12'd6,    12'd2,    1'b0));
    drain_centers();
  endtask

  task automatic test_random_stripes();
    idle_pct  = 0;
    stall_pct = 0;
    apply_config(8'd0, 8'd255);
    send_scan_lines(150, 1);
    apply_config(8'd3, 8'd16);
    send_scan_lines(150, 0);
    drain_centers();
  endtask

  task automatic test_flow_control();
    apply_config(8'd0, 8'd1);
    idle_pct  = 61;
    stall_pct = 0;
    send_scan_lines(120, 0);
    apply_config(8'd1, 8'd40);
    idle_pct  = 0;
    stall_pct = 61;
    send_scan_lines(150, 0);
    apply_config(8'd255, 8'd255);
    idle_pct  = 24;
    stall_pct = 24;
    send_scan_lines(40, 0);
    apply_config(8'd2, 8'd255);
    send_scan_lines(150, 0);
    drain_centers();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall at random at the current rate.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    center_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted center item with the oldest expectation.
  always @(posedge clk) begin
    center_t want;
    if (!rst && center_valid && center_ready) begin
      if (centers_due.size() == 0) begin
        report_mismatch("no center expected", '0, center);
      end else begin
        want = centers_due.pop_front();
        if (center.center_position !== want.center_position)
          report_mismatch("center_position", want, center);
        else if (center.center_line !== want.center_line)
          report_mismatch("center_line", want, center);
        else if (center.stripe_width !== want.stripe_width)
          report_mismatch("stripe_width", want, center);
      end
    end
  end

  // Watchdog: end the run when no item moves for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((pixel_valid && pixel_ready) || (center_valid && center_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_stripe_shapes();
    test_width_limits();
    test_random_stripes();
    test_flow_control();
    drain_centers();
    if (center_errors == 0 && centers_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
